@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, register indexes and saturating Q16.16 helpers for the
// body integrate and bounce step.
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_FORCE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRICTION       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_FACTOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LIMIT   = 3'd6;

	localparam logic [31:0] RST_INVERSE_MASS  = 32'd65536;
	localparam logic [15:0] RST_BOUNCE_FACTOR = 16'd32768;
	localparam logic [15:0] RST_RIGHT_LIMIT   = 16'd1900;
	localparam logic [15:0] RST_BOTTOM_LIMIT  = 16'd1020;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [31:0]        inverse_mass;
		logic               gravity_enable;
		logic signed [31:0] gravity_force;
		logic [15:0]        friction_coefficient;
		logic [15:0]        bounce_factor;
		logic [15:0]        right_limit;
		logic [15:0]        bottom_limit;
	} cfg_t;

	// Multiplier operations; each one is issued in one state and written back
	// in the next.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_AX,
		OP_AY,
		OP_VX,
		OP_VY,
		OP_PX,
		OP_PY,
		OP_FX,
		OP_FY,
		OP_BX,
		OP_BY
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AX,
		ST_AY,
		ST_VX,
		ST_VY,
		ST_PX,
		ST_PY,
		ST_FX,
		ST_FY,
		ST_BX,
		ST_BY,
		ST_LAST,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_in;
		op_t  issue;
		op_t  wb;
		logic publish;
	} cmd_t;

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			add_sat = s[32] ? Q_MIN : Q_MAX;
		end else begin
			add_sat = s[31:0];
		end
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
		if (a == Q_MIN) begin
			neg_sat = Q_MAX;
		end else begin
			neg_sat = -a;
		end
	endfunction

	// Arithmetic shift by 16 rounds toward minus infinity, then saturate.
	function automatic logic signed [31:0] scale_sat(input logic signed [63:0] p);
		logic signed [47:0] s;
		s = p[63:16];
		if (s > 48'sh0000_7FFF_FFFF) begin
			scale_sat = Q_MAX;
		end else if (s < -48'sh0000_8000_0000) begin
			scale_sat = Q_MIN;
		end else begin
			scale_sat = s[31:0];
		end
	endfunction

endpackage

@@ rtl/bis_cfg.sv @@
// ----------------------------------------------------------------------------
// bis_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module bis_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bis_pkg::cfg_t                     cfg
);

	bis_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inverse_mass         <= bis_pkg::RST_INVERSE_MASS;
			cfg_q.gravity_enable       <= 1'b0;
			cfg_q.gravity_force        <= '0;
			cfg_q.friction_coefficient <= '0;
			cfg_q.bounce_factor        <= bis_pkg::RST_BOUNCE_FACTOR;
			cfg_q.right_limit          <= bis_pkg::RST_RIGHT_LIMIT;
			cfg_q.bottom_limit         <= bis_pkg::RST_BOTTOM_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				bis_pkg::CFG_INVERSE_MASS:   cfg_q.inverse_mass <= cfg_data;
				bis_pkg::CFG_GRAVITY_ENABLE: cfg_q.gravity_enable <= cfg_data[0];
				bis_pkg::CFG_GRAVITY_FORCE:  cfg_q.gravity_force <= cfg_data;
				bis_pkg::CFG_FRICTION:       cfg_q.friction_coefficient <= cfg_data[15:0];
				bis_pkg::CFG_BOUNCE_FACTOR:  cfg_q.bounce_factor <= cfg_data[15:0];
				bis_pkg::CFG_RIGHT_LIMIT:    cfg_q.right_limit <= cfg_data[15:0];
				bis_pkg::CFG_BOTTOM_LIMIT:   cfg_q.bottom_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/bis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer: steps the shared multiplier through the ten products of one
// tick and owns the request handshakes.
// ----------------------------------------------------------------------------
module bis_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bis_pkg::cmd_t cmd
);

	bis_pkg::state_t state_q;
	bis_pkg::state_t state_next;
	logic            out_valid_q;
	logic            room;

	assign room = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bis_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			bis_pkg::ST_IDLE: if (in_valid) state_next = bis_pkg::ST_AX;
			bis_pkg::ST_AX:   state_next = bis_pkg::ST_AY;
			bis_pkg::ST_AY:   state_next = bis_pkg::ST_VX;
			bis_pkg::ST_VX:   state_next = bis_pkg::ST_VY;
			bis_pkg::ST_VY:   state_next = bis_pkg::ST_PX;
			bis_pkg::ST_PX:   state_next = bis_pkg::ST_PY;
			bis_pkg::ST_PY:   state_next = bis_pkg::ST_FX;
			bis_pkg::ST_FX:   state_next = bis_pkg::ST_FY;
			bis_pkg::ST_FY:   state_next = bis_pkg::ST_BX;
			bis_pkg::ST_BX:   state_next = bis_pkg::ST_BY;
			bis_pkg::ST_BY:   state_next = bis_pkg::ST_LAST;
			bis_pkg::ST_LAST: state_next = bis_pkg::ST_FIN;
			bis_pkg::ST_FIN:  if (room) state_next = bis_pkg::ST_IDLE;
			default:          state_next = bis_pkg::ST_IDLE;
		endcase
	end

	// Each state from AX to BY issues one product; each state from AY to LAST writes back the one issued before it.
	always_comb begin
		cmd.load_in = 1'b0;
		cmd.issue   = bis_pkg::OP_NONE;
		cmd.wb      = bis_pkg::OP_NONE;
		cmd.publish = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			bis_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			bis_pkg::ST_AX: cmd.issue = bis_pkg::OP_AX;
			bis_pkg::ST_AY: begin
				cmd.issue = bis_pkg::OP_AY;
				cmd.wb    = bis_pkg::OP_AX;
			end
			bis_pkg::ST_VX: begin
				cmd.issue = bis_pkg::OP_VX;
				cmd.wb    = bis_pkg::OP_AY;
			end
			bis_pkg::ST_VY: begin
				cmd.issue = bis_pkg::OP_VY;
				cmd.wb    = bis_pkg::OP_VX;
			end
			bis_pkg::ST_PX: begin
				cmd.issue = bis_pkg::OP_PX;
				cmd.wb    = bis_pkg::OP_VY;
			end
			bis_pkg::ST_PY: begin
				cmd.issue = bis_pkg::OP_PY;
				cmd.wb    = bis_pkg::OP_PX;
			end
			bis_pkg::ST_FX: begin
				cmd.issue = bis_pkg::OP_FX;
				cmd.wb    = bis_pkg::OP_PY;
			end
			bis_pkg::ST_FY: begin
				cmd.issue = bis_pkg::OP_FY;
				cmd.wb    = bis_pkg::OP_FX;
			end
			bis_pkg::ST_BX: begin
				cmd.issue = bis_pkg::OP_BX;
				cmd.wb    = bis_pkg::OP_FY;
			end
			bis_pkg::ST_BY: begin
				cmd.issue = bis_pkg::OP_BY;
				cmd.wb    = bis_pkg::OP_BX;
			end
			bis_pkg::ST_LAST: cmd.wb = bis_pkg::OP_BY;
			bis_pkg::ST_FIN:  cmd.publish = room;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/bis_dp.sv @@
// ----------------------------------------------------------------------------
// bis_dp
// Datapath: body state, one shared 32x33 multiplier with a product register,
// saturating write-back and the result registers.
// ----------------------------------------------------------------------------
module bis_dp #(
	parameter int unsigned START_X = 960,
	parameter int unsigned START_Y = 540
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bis_pkg::cmd_t      cmd,
	input  bis_pkg::cfg_t      cfg,
	input  logic [15:0]        delta_time,
	input  logic signed [31:0] extra_force_x,
	input  logic signed [31:0] extra_force_y,
	input  logic               drag_active,
	input  logic signed [31:0] drag_x,
	input  logic signed [31:0] drag_y,
	output logic signed [31:0] out_position_x,
	output logic signed [31:0] out_position_y,
	output logic signed [31:0] out_velocity_x,
	output logic signed [31:0] out_velocity_y
);

	localparam longint StartXFull = longint'(START_X) * 65536;
	localparam longint StartYFull = longint'(START_Y) * 65536;
	localparam logic signed [31:0] START_X_Q =
		(StartXFull > 64'sh7FFF_FFFF) ? bis_pkg::Q_MAX : StartXFull[31:0];
	localparam logic signed [31:0] START_Y_Q =
		(StartYFull > 64'sh7FFF_FFFF) ? bis_pkg::Q_MAX : StartYFull[31:0];

	logic signed [31:0] px_q, py_q, vx_q, vy_q, pfx_q, pfy_q;
	logic signed [31:0] ax_q, ay_q;
	logic [15:0]        dt_q;
	logic               drag_q;
	logic signed [31:0] drag_x_q, drag_y_q;

	logic signed [31:0] mul_a;
	logic [31:0]        mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] prod_q;
	logic signed [31:0] m;
	logic signed [31:0] m_neg;

	logic               hit_right, hit_left, hit_bottom, hit_top;
	logic signed [31:0] wall_x, wall_y;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.issue)
			bis_pkg::OP_AX: begin mul_a = pfx_q; mul_b = cfg.inverse_mass; end
			bis_pkg::OP_AY: begin mul_a = pfy_q; mul_b = cfg.inverse_mass; end
			bis_pkg::OP_VX: begin mul_a = ax_q;  mul_b = {16'h0, dt_q}; end
			bis_pkg::OP_VY: begin mul_a = ay_q;  mul_b = {16'h0, dt_q}; end
			bis_pkg::OP_PX: begin mul_a = vx_q;  mul_b = {16'h0, dt_q}; end
			bis_pkg::OP_PY: begin mul_a = vy_q;  mul_b = {16'h0, dt_q}; end
			bis_pkg::OP_FX: begin mul_a = vx_q;  mul_b = {16'h0, cfg.friction_coefficient}; end
			bis_pkg::OP_FY: begin mul_a = vy_q;  mul_b = {16'h0, cfg.friction_coefficient}; end
			bis_pkg::OP_BX: begin mul_a = vx_q;  mul_b = {16'h0, cfg.bounce_factor}; end
			bis_pkg::OP_BY: begin mul_a = vy_q;  mul_b = {16'h0, cfg.bounce_factor}; end
			default: ;
		endcase
	end

	assign prod  = mul_a * $signed({1'b0, mul_b});
	assign m     = bis_pkg::scale_sat(prod_q);
	assign m_neg = bis_pkg::neg_sat(m);

	// A limit of 32768 pixels or more lies beyond the Q16.16 range: it never
	// triggers and its clamp value saturates.
	assign hit_right  = !cfg.right_limit[15] &&
		(px_q > $signed({1'b0, cfg.right_limit[14:0], 16'h0}));
	assign hit_left   = px_q[31];
	assign hit_bottom = !cfg.bottom_limit[15] &&
		(py_q > $signed({1'b0, cfg.bottom_limit[14:0], 16'h0}));
	assign hit_top    = py_q[31];
	assign wall_x = cfg.right_limit[15] ? bis_pkg::Q_MAX : {cfg.right_limit, 16'h0};
	assign wall_y = cfg.bottom_limit[15] ? bis_pkg::Q_MAX : {cfg.bottom_limit, 16'h0};

	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (cmd.load_in) begin
			dt_q     <= delta_time;
			drag_q   <= drag_active;
			drag_x_q <= drag_x;
			drag_y_q <= drag_y;
		end
		if (cmd.wb == bis_pkg::OP_AX) ax_q <= m;
		if (cmd.wb == bis_pkg::OP_AY) ay_q <= m;
		if (cmd.publish) begin
			out_position_x <= px_q;
			out_position_y <= py_q;
			out_velocity_x <= vx_q;
			out_velocity_y <= vy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= START_X_Q;
			py_q  <= START_Y_Q;
			vx_q  <= '0;
			vy_q  <= '0;
			pfx_q <= '0;
			pfy_q <= '0;
		end else begin
			if (cmd.load_in) begin
				pfx_q <= bis_pkg::add_sat(pfx_q, extra_force_x);
				pfy_q <= bis_pkg::add_sat(pfy_q, extra_force_y);
			end
			case (cmd.wb)
				bis_pkg::OP_VX: vx_q <= bis_pkg::add_sat(vx_q, m);
				bis_pkg::OP_VY: vy_q <= bis_pkg::add_sat(vy_q, m);
				bis_pkg::OP_PX: px_q <= drag_q ? drag_x_q : bis_pkg::add_sat(px_q, m);
				bis_pkg::OP_PY: py_q <= drag_q ? drag_y_q : bis_pkg::add_sat(py_q, m);
				bis_pkg::OP_FX: pfx_q <= cfg.gravity_enable ? m_neg : '0;
				bis_pkg::OP_FY: begin
					pfy_q <= cfg.gravity_enable ?
						bis_pkg::add_sat(cfg.gravity_force, m_neg) : '0;
				end
				// The right clamp is never negative, so at most one of the
				// two walls on an axis acts, and a single product serves both.
				bis_pkg::OP_BX: begin
					if (hit_right) begin
						vx_q <= m_neg;
						px_q <= wall_x;
					end else if (hit_left) begin
						vx_q <= m_neg;
						px_q <= '0;
					end
				end
				bis_pkg::OP_BY: begin
					if (hit_bottom) begin
						vy_q <= m_neg;
						py_q <= wall_y;
					end else if (hit_top) begin
						vy_q <= m_neg;
						py_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/body_integrate_bounce_step.sv @@
// ----------------------------------------------------------------------------
// body_integrate_bounce_step
// One semi-implicit Euler tick of a single body in Q16.16, with saturating
// arithmetic, optional gravity and friction, drag override and wall bounce.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -------------------------------------------
//  in        in_valid / in_ready    delta_time, extra_force_x/y, drag_active,
//                                   drag_x/y
//  out       out_valid / out_ready  out_position_x/y, out_velocity_x/y
//  cfg       cfg_write              cfg_index, cfg_data (no read-back)
//
//  Ten products of a request run in sequence on one shared multiplier, each
//  written back in the cycle after its issue. in_ready is high only while
//  the sequencer is idle, so one request is in work at a time and a new one
//  is taken only after the previous result has been loaded.
//  The result register holds until taken; a finished request waits in its
//  last step while an earlier result is still unclaimed.
//  Reset places the body at the start position with zero velocity and force.
//
module body_integrate_bounce_step #(
	parameter int unsigned START_X = 960,
	parameter int unsigned START_Y = 540
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    delta_time,
	input  logic signed [31:0]             extra_force_x,
	input  logic signed [31:0]             extra_force_y,
	input  logic                           drag_active,
	input  logic signed [31:0]             drag_x,
	input  logic signed [31:0]             drag_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             out_position_x,
	output logic signed [31:0]             out_position_y,
	output logic signed [31:0]             out_velocity_x,
	output logic signed [31:0]             out_velocity_y,
	input  logic                           cfg_write,
	input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);

	bis_pkg::cfg_t cfg;
	bis_pkg::cmd_t cmd;

	bis_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bis_dp #(
		.START_X (START_X),
		.START_Y (START_Y)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.delta_time     (delta_time),
		.extra_force_x  (extra_force_x),
		.extra_force_y  (extra_force_y),
		.drag_active    (drag_active),
		.drag_x         (drag_x),
		.drag_y         (drag_y),
		.out_position_x (out_position_x),
		.out_position_y (out_position_y),
		.out_velocity_x (out_velocity_x),
		.out_velocity_y (out_velocity_y)
	);

	// Only one request is in work at a time.
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request accepted while busy");

	// An accepted request starts the multiplier sequence in the next cycle.
	a_sequence_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (cmd.issue == bis_pkg::OP_AX))
		else $error("multiplier sequence did not start");

	// Loading the result register always raises out_valid.
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("result loaded without out_valid");

endmodule

@@ tb/sv/body_step_checker.sv @@
// ----------------------------------------------------------------------------
// body_step_checker
// Watches the tick and result channels of body_integrate_bounce_step, keeps
// its own copy of the body state and register settings, predicts the
// position and velocity after every accepted tick request and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module body_step_checker
	import bis_pkg::*;
#(
	parameter int unsigned START_X = 960,
	parameter int unsigned START_Y = 540
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [15:0]           delta_time,
	input  logic signed [31:0]    extra_force_x,
	input  logic signed [31:0]    extra_force_y,
	input  logic                  drag_active,
	input  logic signed [31:0]    drag_x,
	input  logic signed [31:0]    drag_y,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic signed [31:0]    out_position_x,
	input  logic signed [31:0]    out_position_y,
	input  logic signed [31:0]    out_velocity_x,
	input  logic signed [31:0]    out_velocity_y,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    error_count,
	output int                    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
	} body_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
	} motion_t;

	body_t   body;
	cfg_t    regs;
	motion_t expected_motion[$];

	function automatic logic signed [31:0] clamp_q(input longint v);
		if (v > WORD_MAX) begin
			return WORD_MAX[31:0];
		end else if (v < WORD_MIN) begin
			return WORD_MIN[31:0];
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_q(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp_q(longint'(a) + longint'(b));
	endfunction

	function automatic logic signed [31:0] negate_q(input logic signed [31:0] a);
		return clamp_q(-longint'(a));
	endfunction

	// Exact 64-bit product; the arithmetic shift floors toward minus infinity.
	function automatic logic signed [31:0] scale_q(input logic signed [31:0] a,
			input logic [31:0] f);
		longint prod;
		prod = longint'(a) * longint'({32'd0, f});
		return clamp_q(prod >>> 16);
	endfunction

	function automatic body_t advance(input body_t b, input cfg_t c,
			input logic [15:0] dt, input logic signed [31:0] fx,
			input logic signed [31:0] fy, input logic drag,
			input logic signed [31:0] dx, input logic signed [31:0] dy);
		body_t              n;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		longint             wall_x;
		longint             wall_y;
		n = b;
		wall_x = longint'({48'd0, c.right_limit}) <<< 16;
		wall_y = longint'({48'd0, c.bottom_limit}) <<< 16;

		n.force_x = add_q(n.force_x, fx);
		n.force_y = add_q(n.force_y, fy);
		acc_x = scale_q(n.force_x, c.inverse_mass);
		acc_y = scale_q(n.force_y, c.inverse_mass);
		n.vel_x = add_q(n.vel_x, scale_q(acc_x, {16'd0, dt}));
		n.vel_y = add_q(n.vel_y, scale_q(acc_y, {16'd0, dt}));
		n.pos_x = add_q(n.pos_x, scale_q(n.vel_x, {16'd0, dt}));
		n.pos_y = add_q(n.pos_y, scale_q(n.vel_y, {16'd0, dt}));

		// The force for the next tick starts from zero, plus gravity and drag
		// from the air when gravity is on.
		n.force_x = '0;
		n.force_y = '0;
		if (c.gravity_enable) begin
			n.force_y = c.gravity_force;
			n.force_x = negate_q(scale_q(n.vel_x, {16'd0, c.friction_coefficient}));
			n.force_y = add_q(n.force_y,
				negate_q(scale_q(n.vel_y, {16'd0, c.friction_coefficient})));
		end

		if (drag) begin
			n.pos_x = dx;
			n.pos_y = dy;
		end

		if (longint'(n.pos_x) > wall_x) begin
			n.vel_x = negate_q(scale_q(n.vel_x, {16'd0, c.bounce_factor}));
			n.pos_x = clamp_q(wall_x);
		end
		if (n.pos_x < 0) begin
			n.vel_x = negate_q(scale_q(n.vel_x, {16'd0, c.bounce_factor}));
			n.pos_x = '0;
		end
		if (longint'(n.pos_y) > wall_y) begin
			n.vel_y = negate_q(scale_q(n.vel_y, {16'd0, c.bounce_factor}));
			n.pos_y = clamp_q(wall_y);
		end
		if (n.pos_y < 0) begin
			n.vel_y = negate_q(scale_q(n.vel_y, {16'd0, c.bounce_factor}));
			n.pos_y = '0;
		end
		return n;
	endfunction

	task automatic compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		motion_t want;
		if (!arst_n) begin
			body.pos_x = clamp_q(longint'(START_X) * 65536);
			body.pos_y = clamp_q(longint'(START_Y) * 65536);
			body.vel_x = '0;
			body.vel_y = '0;
			body.force_x = '0;
			body.force_y = '0;
			regs.inverse_mass = RST_INVERSE_MASS;
			regs.gravity_enable = 1'b0;
			regs.gravity_force = '0;
			regs.friction_coefficient = '0;
			regs.bounce_factor = RST_BOUNCE_FACTOR;
			regs.right_limit = RST_RIGHT_LIMIT;
			regs.bottom_limit = RST_BOTTOM_LIMIT;
			expected_motion.delete();
			error_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_motion.size() == 0) begin
					$error("result with no request waiting: position %0d,%0d",
						out_position_x, out_position_y);
					error_count++;
				end else begin
					want = expected_motion.pop_front();
					compare_field("out_position_x", want.pos_x, out_position_x);
					compare_field("out_position_y", want.pos_y, out_position_y);
					compare_field("out_velocity_x", want.vel_x, out_velocity_x);
					compare_field("out_velocity_y", want.vel_y, out_velocity_y);
				end
			end
			if (in_valid && in_ready) begin
				body = advance(body, regs, delta_time, extra_force_x, extra_force_y,
					drag_active, drag_x, drag_y);
				want.pos_x = body.pos_x;
				want.pos_y = body.pos_y;
				want.vel_x = body.vel_x;
				want.vel_y = body.vel_y;
				expected_motion.push_back(want);
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_INVERSE_MASS:   regs.inverse_mass = cfg_data[31:0];
					CFG_GRAVITY_ENABLE: regs.gravity_enable = cfg_data[0];
					CFG_GRAVITY_FORCE:  regs.gravity_force = cfg_data[31:0];
					CFG_FRICTION:       regs.friction_coefficient = cfg_data[15:0];
					CFG_BOUNCE_FACTOR:  regs.bounce_factor = cfg_data[15:0];
					CFG_RIGHT_LIMIT:    regs.right_limit = cfg_data[15:0];
					CFG_BOTTOM_LIMIT:   regs.bottom_limit = cfg_data[15:0];
					default: begin
					end
				endcase
			end
		end
		pending_count = expected_motion.size();
	end

endmodule

@@ tb/sv/tb_body_integrate_bounce_step.sv @@
// ----------------------------------------------------------------------------
// tb_body_integrate_bounce_step
// Drives tick requests and register settings into body_integrate_bounce_step
// with random gaps on both channels: a short directed set of extreme forces,
// drags past every wall and extreme settings, then random phases of mostly
// realistic motion mixed with raw noise. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_body_integrate_bounce_step;
	import bis_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned START_X        = 960;
	localparam int unsigned START_Y        = 540;
	localparam int          RANDOM_PHASES  = 12;
	localparam int          TICKS_PER_PHASE = 150;
	localparam int          TIMEOUT_NS     = 10_000_000;

	typedef struct packed {
		logic [15:0]        dt;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic               drag;
		logic signed [31:0] drag_x;
		logic signed [31:0] drag_y;
	} tick_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [15:0]           delta_time;
	logic signed [31:0]    extra_force_x;
	logic signed [31:0]    extra_force_y;
	logic                  drag_active;
	logic signed [31:0]    drag_x;
	logic signed [31:0]    drag_y;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [31:0]    out_position_x;
	logic signed [31:0]    out_position_y;
	logic signed [31:0]    out_velocity_x;
	logic signed [31:0]    out_velocity_y;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    error_count;
	int                    pending_count;

	body_integrate_bounce_step #(
		.START_X(START_X),
		.START_Y(START_Y)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.delta_time    (delta_time),
		.extra_force_x (extra_force_x),
		.extra_force_y (extra_force_y),
		.drag_active   (drag_active),
		.drag_x        (drag_x),
		.drag_y        (drag_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_position_x(out_position_x),
		.out_position_y(out_position_y),
		.out_velocity_x(out_velocity_x),
		.out_velocity_y(out_velocity_y),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	body_step_checker #(
		.START_X(START_X),
		.START_Y(START_Y)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.delta_time    (delta_time),
		.extra_force_x (extra_force_x),
		.extra_force_y (extra_force_y),
		.drag_active   (drag_active),
		.drag_x        (drag_x),
		.drag_y        (drag_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_position_x(out_position_x),
		.out_position_y(out_position_y),
		.out_velocity_x(out_velocity_x),
		.out_velocity_y(out_velocity_y),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_body_integrate_bounce_step: errors");
		$finish;
	end

	function automatic logic signed [31:0] px(input int p);
		return p <<< 16;
	endfunction

	function automatic logic signed [31:0] around_zero(input int unsigned half);
		return int'($urandom_range(0, 2 * half)) - int'(half);
	endfunction

	function automatic logic signed [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 11))
			0: return 16'd0;
			1: return 16'd32767;
			2: return 16'd32768;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(200, 2000));
		endcase
	endfunction

	function automatic tick_req_t make_tick(input logic [15:0] dt,
			input logic signed [31:0] fx, input logic signed [31:0] fy,
			input logic drag, input logic signed [31:0] dx,
			input logic signed [31:0] dy);
		tick_req_t t;
		t.dt = dt;
		t.force_x = fx;
		t.force_y = fy;
		t.drag = drag;
		t.drag_x = dx;
		t.drag_y = dy;
		return t;
	endfunction

	// Called at a falling edge; returns at a falling edge. With no gap the
	// valid stays high into the next request.
	task automatic send_tick(input tick_req_t t, input bit no_gap);
		int gap;
		in_valid <= 1'b1;
		delta_time <= t.dt;
		extra_force_x <= t.force_x;
		extra_force_y <= t.force_y;
		drag_active <= t.drag;
		drag_x <= t.drag_x;
		drag_y <= t.drag_y;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		gap = no_gap ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic apply_setting(input cfg_t s);
		write_reg(CFG_INVERSE_MASS, s.inverse_mass);
		write_reg(CFG_GRAVITY_ENABLE, {31'd0, s.gravity_enable});
		write_reg(CFG_GRAVITY_FORCE, s.gravity_force);
		write_reg(CFG_FRICTION, {16'd0, s.friction_coefficient});
		write_reg(CFG_BOUNCE_FACTOR, {16'd0, s.bounce_factor});
		write_reg(CFG_RIGHT_LIMIT, {16'd0, s.right_limit});
		write_reg(CFG_BOTTOM_LIMIT, {16'd0, s.bottom_limit});
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Result side: a random stall before each result, with stretches of none.
	initial begin : result_sink
		int  hold;
		bit  streak;
		out_ready = 1'b0;
		streak = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = streak ? 0 : $urandom_range(0, 10);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
			if ($urandom_range(0, 49) == 0) begin
				streak = !streak;
			end
		end
	end

	initial begin : stimulus
		tick_req_t t;
		cfg_t      s;
		bit        streak;
		in_valid = 1'b0;
		delta_time = '0;
		extra_force_x = '0;
		extra_force_y = '0;
		drag_active = 1'b0;
		drag_x = '0;
		drag_y = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_INVERSE_MASS;
		cfg_data = '0;
		streak = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Settings as they come out of reset.
		send_tick(make_tick(16'd0, 0, 0, 1'b0, 0, 0), 1'b0);
		send_tick(make_tick(16'hFFFF, Q_MAX, Q_MIN, 1'b0, 0, 0), 1'b0);
		send_tick(make_tick(16'hFFFF, Q_MAX, Q_MAX, 1'b0, 0, 0), 1'b0);
		send_tick(make_tick(16'd1092, -32'sd1, -32'sd1, 1'b0, Q_MAX, Q_MIN), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, px(2000), px(500)), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, -px(5), -px(3)), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, px(100), px(1500)), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, Q_MAX, Q_MIN), 1'b0);
		send_tick(make_tick(16'hFFFF, Q_MIN, Q_MIN, 1'b1, Q_MIN, Q_MAX), 1'b0);
		send_tick(make_tick(16'd1, 32'sd1, -32'sd1, 1'b1, 0, 0), 1'b0);

		// Heaviest scaling everywhere, and walls at zero so both tests of an
		// axis can run on the same tick.
		settle();
		s = '{inverse_mass: 32'hFFFF_FFFF, gravity_enable: 1'b1, gravity_force: Q_MIN,
			friction_coefficient: 16'hFFFF, bounce_factor: 16'hFFFF,
			right_limit: 16'd0, bottom_limit: 16'd0};
		apply_setting(s);
		send_tick(make_tick(16'd1092, px(1), 0, 1'b0, 0, 0), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, px(1), px(1)), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, -32'sd1, -32'sd1), 1'b0);
		send_tick(make_tick(16'hFFFF, Q_MIN, Q_MAX, 1'b0, 0, 0), 1'b0);
		send_tick(make_tick(16'd0, 0, 0, 1'b0, 0, 0), 1'b0);

		// Walls beyond the Q16.16 range never fire.
		settle();
		s = '{inverse_mass: 32'd1, gravity_enable: 1'b1, gravity_force: Q_MAX,
			friction_coefficient: 16'd0, bounce_factor: 16'd0,
			right_limit: 16'hFFFF, bottom_limit: 16'hFFFF};
		apply_setting(s);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, Q_MAX, Q_MAX), 1'b0);
		send_tick(make_tick(16'hFFFF, Q_MAX, Q_MAX, 1'b0, 0, 0), 1'b0);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, -32'sd1, -32'sd1), 1'b0);

		// Largest wall that still fits, and the first one that does not.
		settle();
		s = '{inverse_mass: RST_INVERSE_MASS, gravity_enable: 1'b0, gravity_force: '0,
			friction_coefficient: 16'd1, bounce_factor: RST_BOUNCE_FACTOR,
			right_limit: 16'd32767, bottom_limit: 16'd32768};
		apply_setting(s);
		send_tick(make_tick(16'd1092, 0, 0, 1'b1, Q_MAX, Q_MAX), 1'b0);
		send_tick(make_tick(16'd2000, px(10), -px(10), 1'b0, 0, 0), 1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case ($urandom_range(0, 5))
				0: s.inverse_mass = 32'd1;
				1: s.inverse_mass = 32'hFFFF_FFFF;
				2: s.inverse_mass = $urandom_range(1, 32'hFFFF_FFFF);
				default: s.inverse_mass = $urandom_range(1 << 14, 1 << 18);
			endcase
			s.gravity_enable = $urandom_range(0, 3) != 0;
			s.gravity_force = ($urandom_range(0, 4) == 0) ? edge_word()
				: around_zero(1_500_000);
			s.friction_coefficient = ($urandom_range(0, 3) == 0)
				? 16'($urandom_range(0, 16'hFFFF)) : 16'($urandom_range(0, 3000));
			case ($urandom_range(0, 5))
				0: s.bounce_factor = 16'd0;
				1: s.bounce_factor = 16'hFFFF;
				default: s.bounce_factor = 16'($urandom_range(16384, 60000));
			endcase
			s.right_limit = pick_limit();
			s.bottom_limit = pick_limit();
			apply_setting(s);

			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				if ($urandom_range(0, 39) == 0) begin
					streak = !streak;
				end
				if ($urandom_range(0, 59) == 0) begin
					settle();
				end
				if ($urandom_range(0, 9) < 7) begin
					// Frame-sized steps and moderate forces keep the body moving
					// between the walls, with the odd drag past them.
					t.dt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF))
						: 16'($urandom_range(400, 2200));
					t.force_x = ($urandom_range(0, 2) == 0) ? '0 : around_zero(px(500));
					t.force_y = ($urandom_range(0, 2) == 0) ? '0 : around_zero(px(500));
					t.drag = $urandom_range(0, 7) == 0;
					t.drag_x = int'($urandom_range(0, px(3000))) - px(500);
					t.drag_y = int'($urandom_range(0, px(3000))) - px(500);
				end else begin
					t.dt = 16'($urandom_range(0, 16'hFFFF));
					t.force_x = edge_word();
					t.force_y = edge_word();
					t.drag = 1'($urandom_range(0, 1));
					t.drag_x = edge_word();
					t.drag_y = edge_word();
				end
				send_tick(t, streak);
			end
		end

		settle();
		repeat (20) @(negedge clk);
		if (error_count == 0 && pending_count == 0) begin
			$display("tb_body_integrate_bounce_step: clean");
		end else begin
			$display("tb_body_integrate_bounce_step: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/bis_pkg.sv
rtl/bis_cfg.sv
rtl/bis_ctrl.sv
rtl/bis_dp.sv
rtl/body_integrate_bounce_step.sv
tb/sv/body_step_checker.sv
tb/sv/tb_body_integrate_bounce_step.sv
